FILE: rtl/sold_pkg.sv
// Shared constants, tables, types and command structs of the sine light dimmer.
`timescale 1ns / 1ps
package sold_pkg;

	localparam int SINE_TABLE_ENTRIES = 1024;
	localparam int PHASE_BITS         = 32;
	localparam int IDX_BITS           = $clog2(SINE_TABLE_ENTRIES);
	localparam int ROM_W              = 17;

	localparam int DELTA_W     = 16;
	localparam int FREQ_W      = 16;
	localparam int PEAK_W      = 8;
	localparam int PCT_W       = 8;
	localparam int LEVEL_W     = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int INC_MULT_W = 23;
	localparam logic [INC_MULT_W-1:0] INC_MULT = INC_MULT_W'(4398047);
	localparam int INC_SHIFT  = 10 + 32 - PHASE_BITS;
	localparam int INC_W      = FREQ_W + INC_MULT_W - INC_SHIFT;
	localparam int STEP_W     = INC_W + DELTA_W;
	localparam int PROD_W     = ROM_W + PEAK_W;

	localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1000);
	localparam logic [PEAK_W-1:0] PEAK_RESET = PEAK_W'(255);
	localparam logic [PCT_W-1:0]  PCT_RESET  = '0;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FREQ   = 2'd0,
		REG_PEAK   = 2'd1,
		REG_OFFSET = 2'd2
	} cfg_reg_t;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint          ONE_Q30     = 64'sd1 << 30;
	localparam longint          ROUND_Q15   = 64'sd1 << 14;
	localparam int unsigned     TAYLOR_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};
	localparam longint          PERCENT_DIV = 64'sd100;

	typedef logic [ROM_W-1:0]      sine_rom_t [SINE_TABLE_ENTRIES];
	typedef logic [PHASE_BITS-1:0] off_rom_t  [2**PCT_W];

	// Sine of a first-quadrant angle in Q30 radians, Taylor series up to x^17.
	function automatic longint sin_q30(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		int              k;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
			if (k[0]) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return sum;
	endfunction

	// Table of (1 + sin) / 2 in Q16, built by quarter-wave folding.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t       rom;
		longint unsigned f;
		longint unsigned r;
		longint unsigned x;
		longint          s;
		logic [1:0]      quad;
		int              i;
		for (i = 0; i < SINE_TABLE_ENTRIES; i++) begin
			f    = (longint'(i) << 32) / SINE_TABLE_ENTRIES;
			quad = f[31:30];
			r    = f & ((64'd1 << 30) - 64'd1);
			if (quad[0]) begin
				r = (64'd1 << 30) - r;
			end
			x = (r * HALF_PI_Q30) >> 30;
			s = sin_q30(x);
			if (quad[1]) begin
				s = -s;
			end
			rom[i] = ROM_W'((ONE_Q30 + s + ROUND_Q15) >>> 15);
		end
		return rom;
	endfunction

	// Phase offset for every raw percent code, truncated toward zero.
	function automatic off_rom_t build_offset_rom();
		off_rom_t rom;
		longint   p;
		longint   offs;
		int       b;
		for (b = 0; b < 2**PCT_W; b++) begin
			p = (b >= 2**(PCT_W-1)) ? longint'(b) - longint'(2**PCT_W) : longint'(b);
			offs   = (p * (64'sd1 <<< PHASE_BITS)) / PERCENT_DIV;
			rom[b] = PHASE_BITS'(offs);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM   = build_sine_rom();
	localparam off_rom_t  OFFSET_ROM = build_offset_rom();

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_STEP,
		ST_ACC,
		ST_READ,
		ST_SCALE
	} ctrl_state_t;

	typedef struct packed {
		logic load_in;
		logic mul_inc;
		logic mul_step;
		logic advance;
		logic read_rom;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctrl_stat_t;

endpackage

FILE: rtl/sold_ctrl.sv
// Controller state machine that sequences one tick through the datapath.
`timescale 1ns / 1ps
module sold_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sold_pkg::ctrl_stat_t stat,
	output sold_pkg::ctrl_cmd_t  cmd
);
	import sold_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_INC;
				end
			end
			ST_INC: begin
				cmd.mul_inc = 1'b1;
				state_d     = ST_STEP;
			end
			ST_STEP: begin
				cmd.mul_step = 1'b1;
				state_d      = ST_ACC;
			end
			ST_ACC: begin
				cmd.advance = 1'b1;
				state_d     = ST_READ;
			end
			ST_READ: begin
				cmd.read_rom = 1'b1;
				state_d      = ST_SCALE;
			end
			ST_SCALE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/sold_datapath.sv
// Datapath: settings, phase accumulator, sine table lookup, scaling and output register.
`timescale 1ns / 1ps
module sold_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [sold_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sold_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [sold_pkg::DELTA_W-1:0]     elapsed_ms,
	input  logic                            enabled,
	input  sold_pkg::ctrl_cmd_t              cmd,
	output sold_pkg::ctrl_stat_t             stat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sold_pkg::LEVEL_W-1:0]     pwm_level
);
	import sold_pkg::*;

	logic [FREQ_W-1:0]     freq_q;
	logic [PEAK_W-1:0]     peak_q;
	logic [PCT_W-1:0]      pct_q;
	logic [PHASE_BITS-1:0] phase_acc_q;
	logic                  out_valid_q;

	logic [DELTA_W-1:0]    delta_q;
	logic                  enabled_q;
	logic [INC_W-1:0]      inc_q;
	logic [PHASE_BITS-1:0] step_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [ROM_W-1:0]      rom_q;
	logic [LEVEL_W-1:0]    level_q;

	logic [FREQ_W-1:0]              freq_eff;
	logic [FREQ_W+INC_MULT_W-1:0]   inc_full;
	logic [STEP_W-1:0]              step_full;
	logic [PHASE_BITS-1:0]          phase_next;
	logic [PHASE_BITS-1:0]          phase_pos;
	logic [PROD_W-1:0]              prod;

	assign freq_eff   = (freq_q == '0) ? FREQ_W'(1) : freq_q;
	assign inc_full   = freq_eff * INC_MULT;
	assign step_full  = inc_q * delta_q;
	assign phase_next = phase_acc_q + step_q;
	assign phase_pos  = phase_next + OFFSET_ROM[pct_q];
	assign prod       = rom_q * peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q      <= FREQ_RESET;
			peak_q      <= PEAK_RESET;
			pct_q       <= PCT_RESET;
			phase_acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_FREQ:   freq_q <= cfg_data[FREQ_W-1:0];
					REG_PEAK:   peak_q <= cfg_data[PEAK_W-1:0];
					REG_OFFSET: pct_q  <= cfg_data[PCT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.advance && enabled_q) begin
				phase_acc_q <= phase_next;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			delta_q   <= elapsed_ms;
			enabled_q <= enabled;
		end
		if (cmd.mul_inc) begin
			inc_q <= inc_full[INC_SHIFT +: INC_W];
		end
		if (cmd.mul_step) begin
			step_q <= step_full[PHASE_BITS-1:0];
		end
		if (cmd.advance) begin
			idx_q <= phase_pos[PHASE_BITS-1 -: IDX_BITS];
		end
		if (cmd.read_rom) begin
			rom_q <= SINE_ROM[idx_q];
		end
		if (cmd.load_out) begin
			level_q <= enabled_q ? prod[16 +: LEVEL_W] : '0;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign pwm_level     = level_q;

endmodule

FILE: rtl/sine_oscillating_light_dimmer.sv
// Top level of the sine-wave light dimmer with stream ports and a settings write port.
`timescale 1ns / 1ps
// Each input transfer is one time tick carrying the milliseconds since the last tick and an
// enable flag; each tick yields exactly one PWM level. While enabled, a 32-bit phase in turns
// advances by the frequency increment times the elapsed time, the phase offset is added and
// the top bits select a 1024-entry (1 + sin) / 2 table, scaled by the peak level. A disabled
// tick gives level 0 and holds the phase. A tick passes from acceptance to a result in the
// output register through the controller's walk through the increment multiply, step
// multiply, phase update, table read and peak scaling, waiting at the scaling step until
// the output register is free or drained; a new tick is taken only after that.
// The settings port takes a write in every cycle; indexes past the register list are ignored.
module sine_oscillating_light_dimmer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sold_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sold_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,   // elapsed_ms
	input  logic                             s_tuser,   // enabled
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata    // pwm_level
);
	import sold_pkg::*;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	assign cfg_ready = 1'b1;

	sold_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sold_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.elapsed_ms (s_tdata[DELTA_W-1:0]),
		.enabled    (s_tuser),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.pwm_level  (m_tdata)
	);

endmodule
